@@ hdl/wbps_pkg.sv @@
// Package for the wildcard byte pattern search block.
// Holds the payload types, the configuration register codes and shared constants.
// No dependencies.
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int PAT_BYTES = 16;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_REG_W = 5;
  localparam int OUT_OFFSET_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] WILDCARD = 8'h00;
  localparam logic [LEN_REG_W-1:0] LENGTH_RESET = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_index_e;

  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

@@ hdl/wbps_if.sv @@
// Stream interfaces for the input bytes and the search results.
// Depends on wbps_pkg for the payload types.
interface wbps_in_if;
  logic               valid;
  logic               ready;
  wbps_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wbps_out_if;
  logic                valid;
  logic                ready;
  wbps_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/wbps_cfg_regs.sv @@
// Configuration registers: the sixteen pattern bytes and the pattern length.
// Depends on wbps_pkg for the register codes and widths.
module wbps_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wbps_pkg::CFG_W-1:0]          cfg_data_i,
  output wbps_pkg::pattern_t                  pattern_o,
  output logic [wbps_pkg::LEN_REG_W-1:0]      length_o
);

  logic [wbps_pkg::CFG_W-1:0]     pat_low_q, pat_low_d;
  logic [wbps_pkg::CFG_W-1:0]     pat_high_q, pat_high_d;
  logic [wbps_pkg::LEN_REG_W-1:0] length_q, length_d;

  always_comb begin
    pat_low_d = pat_low_q;
    pat_high_d = pat_high_q;
    length_d = length_q;
    if (cfg_we_i) begin
      case (wbps_pkg::cfg_index_e'(cfg_index_i))
        wbps_pkg::CFG_PATTERN_LOW: begin
          pat_low_d = cfg_data_i;
        end
        wbps_pkg::CFG_PATTERN_HIGH: begin
          pat_high_d = cfg_data_i;
        end
        wbps_pkg::CFG_PATTERN_LENGTH: begin
          length_d = cfg_data_i[wbps_pkg::LEN_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q <= '0;
      pat_high_q <= '0;
      length_q <= wbps_pkg::LENGTH_RESET;
    end else begin
      pat_low_q <= pat_low_d;
      pat_high_q <= pat_high_d;
      length_q <= length_d;
    end
  end

  assign pattern_o = {pat_high_q, pat_low_q};
  assign length_o = length_q;

endmodule

@@ hdl/wbps_matcher.sv @@
// Input register, sliding byte window, offset counter and parallel wildcard compare.
// Depends on wbps_pkg for the payload, pattern and result types.
module wbps_matcher #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  wbps_pkg::in_item_t             in_item_i,
  output logic                           in_ready_o,
  input  wbps_pkg::pattern_t             cfg_pattern_i,
  input  logic [wbps_pkg::LEN_REG_W-1:0] cfg_length_i,
  input  logic                           res_free_i,
  output wbps_pkg::result_t              res_o
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int OUT_W = wbps_pkg::OUT_OFFSET_W;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  logic                          inq_valid_q, inq_valid_d;
  logic [wbps_pkg::BYTE_W-1:0]   inq_byte_q, inq_byte_d;
  logic                          inq_last_q, inq_last_d;
  logic [OFFSET_BITS-1:0]        count_q, count_d;
  logic                          reported_q, reported_d;
  logic [wbps_pkg::BYTE_W-1:0]   win_q [PATTERN_MAX];
  logic [wbps_pkg::BYTE_W-1:0]   win_next [PATTERN_MAX];

  logic                   advance;
  logic                   in_accept;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       len_m1;
  logic [PATTERN_MAX-1:0] byte_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;
  logic [OUT_W-1:0]       offset;

  assign advance = inq_valid_q && res_free_i;
  assign in_ready_o = !inq_valid_q || advance;
  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_length_i > wbps_pkg::LEN_REG_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = cfg_length_i[LEN_W-1:0];
    end
    len_m1 = len - LEN_W'(1);
  end

  always_comb begin
    win_next[0] = inq_byte_q;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_next[i] = win_q[i-1];
    end
  end

  // Pattern byte k lines up with the window entry that is len-1-k bytes old.
  always_comb begin
    logic [LEN_W-1:0] pos;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pos = len_m1 - LEN_W'(k);
      if (LEN_W'(k) >= len) begin
        byte_ok[k] = 1'b1;
      end else begin
        byte_ok[k] = (cfg_pattern_i[k] == wbps_pkg::WILDCARD) ||
                     (cfg_pattern_i[k] == win_next[pos[IDX_W-1:0]]);
      end
    end
  end

  assign hit = (&byte_ok) && (len != '0) && (count_q >= OFFSET_BITS'(len_m1));
  assign start = (count_q == COUNT_MAX) ? COUNT_MAX : count_q - OFFSET_BITS'(len_m1);

  if (OFFSET_BITS > OUT_W) begin : g_offset_sat
    assign offset = (|start[OFFSET_BITS-1:OUT_W]) ? {OUT_W{1'b1}} : start[OUT_W-1:0];
  end else begin : g_offset_ext
    assign offset = OUT_W'(start);
  end

  always_comb begin
    res_o.valid = advance && !reported_q && (hit || inq_last_q);
    res_o.item.found = hit && !reported_q;
    res_o.item.match_offset = (hit && !reported_q) ? offset : '0;
  end

  always_comb begin
    inq_valid_d = inq_valid_q;
    inq_byte_d = inq_byte_q;
    inq_last_d = inq_last_q;
    count_d = count_q;
    reported_d = reported_q;
    if (advance) begin
      inq_valid_d = 1'b0;
      if (inq_last_q) begin
        count_d = '0;
        reported_d = 1'b0;
      end else begin
        if (count_q != COUNT_MAX) begin
          count_d = count_q + OFFSET_BITS'(1);
        end
        reported_d = reported_q || hit;
      end
    end
    if (in_accept) begin
      inq_valid_d = 1'b1;
      inq_byte_d = in_item_i.data_byte;
      inq_last_d = in_item_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      count_q <= '0;
      reported_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
      count_q <= count_d;
      reported_q <= reported_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inq_byte_q <= inq_byte_d;
    inq_last_q <= inq_last_d;
    if (advance) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_q[i] <= win_next[i];
      end
    end
  end

`ifndef SYNTH
  a_found_sets_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.found && !inq_last_q) |=> reported_q)
    else $error("A found result did not mark the image as reported.");

  a_not_found_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.item.found) |-> inq_last_q)
    else $error("A not-found result was produced before the last byte.");

  a_silent_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> !res_o.valid)
    else $error("A second result was produced for one image.");

  a_push_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_free_i)
    else $error("A result was produced while the output slot was full.");

  a_rearm_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && inq_last_q) |=> (count_q == '0 && !reported_q))
    else $error("The search did not re-arm after the last byte.");
`endif

endmodule

@@ hdl/wbps_result_reg.sv @@
// Output register that holds one result item until the receiver takes it.
// Depends on wbps_pkg for the result types and on wbps_if for the output channel.
module wbps_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wbps_pkg::result_t res_i,
  output logic              free_o,
  wbps_out_if.source        out_o
);

  logic                valid_q, valid_d;
  wbps_pkg::out_item_t item_q, item_d;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    item_d = item_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
      item_d = res_i.item;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.payload = item_q;

endmodule

@@ hdl/wildcard_byte_pattern_search.sv @@
// Top level of the wildcard byte pattern search block.
// Depends on wbps_pkg, wbps_if, wbps_cfg_regs, wbps_matcher and wbps_result_reg.
//
// Bytes of an image arrive on in_i, one item per byte, with last_byte set on
// the final byte. The block compares each new byte, together with the most
// recent bytes, against the configured pattern, where a zero pattern byte
// matches anything. The first match of an image gives one item on out_o with
// found set and the start offset; an image that ends without a match gives
// one item with found clear on its last byte. Then the search re-arms.
// The pattern is to be written through the cfg_* port while no byte is in
// flight; the block does not enforce this. A byte is taken every cycle while
// the output register is free. An accepted byte sits in the input register
// while the parallel window compare loads the output register, from which
// out_o takes the result. Bytes that cause no result flow through without
// using the output register.
// Reset clears the byte counter, the match flag, the pattern and sets the
// length to one; no clearing pass is needed. While a result waits on out_o,
// one more byte is held in the input register, then in_i.ready drops.
module wildcard_byte_pattern_search #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wbps_pkg::CFG_W-1:0]     cfg_data_i,
  wbps_in_if.sink                        in_i,
  wbps_out_if.source                     out_o
);

  wbps_pkg::pattern_t             pattern;
  logic [wbps_pkg::LEN_REG_W-1:0] length;
  wbps_pkg::result_t              res;
  logic                           res_free;
  logic                           in_ready;

  wbps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern),
    .length_o    (length)
  );

  wbps_matcher #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_matcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_item_i     (in_i.payload),
    .in_ready_o    (in_ready),
    .cfg_pattern_i (pattern),
    .cfg_length_i  (length),
    .res_free_i    (res_free),
    .res_o         (res)
  );

  assign in_i.ready = in_ready;

  wbps_result_reg u_result_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .free_o (res_free),
    .out_o  (out_o)
  );

endmodule
